FILE: src/fdes_pkg.sv
// ----------------------------------------------------------------------------
// fdes_pkg: shared types and constants of the fader smoother
// Field widths, register codes, fixed-point constants and lane interface types.
// ----------------------------------------------------------------------------
package fdes_pkg;

	localparam int LANES           = 5;
	localparam int FIELD_BITS      = 12;
	localparam int CFG_DATA_BITS   = LANES * FIELD_BITS;
	localparam int CFG_INDEX_BITS  = 8;
	localparam int DEF_CHANNELS    = 5;
	localparam int DEF_SAMPLE_BITS = 12;

	// alpha is unsigned Q1.11
	localparam int                    ALPHA_FRAC = 11;
	localparam logic [FIELD_BITS-1:0] ALPHA_ONE  = 12'd2048;
	localparam int                    HALF_LSB   = 1024;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADBAND = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA    = 8'd1;

	typedef struct packed {
		logic [FIELD_BITS-1:0] band;
		logic [FIELD_BITS-1:0] alpha;
	} lane_cfg_t;

	typedef struct packed {
		logic upd;
		logic restart;
	} lane_ctrl_t;

endpackage

FILE: src/fader_deadband_ema_smoother.sv
// ----------------------------------------------------------------------------
// fader_deadband_ema_smoother: five-channel deadband + EMA fader smoother
// Per-channel lanes with a two-entry output buffer and a plain config port.
// ----------------------------------------------------------------------------
// Takes one word of five fader samples per clock while in_stall is low and
// returns one word of five smoothed values through a two-entry output buffer.
// Each lane updates its stored value in the same cycle it accepts a word
// (deadband compare, two 12x12 products, round); this state loop sets the
// rate of one word per cycle while in_stall is low. in_stall rises only when
// both entries are occupied. Channels at or above CHANNELS read as zero.
// ----------------------------------------------------------------------------
module fader_deadband_ema_smoother #(
	parameter int CHANNELS    = fdes_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS = fdes_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	input  logic [fdes_pkg::FIELD_BITS-1:0]     slider_0,
	input  logic [fdes_pkg::FIELD_BITS-1:0]     slider_1,
	input  logic [fdes_pkg::FIELD_BITS-1:0]     slider_2,
	input  logic [fdes_pkg::FIELD_BITS-1:0]     slider_3,
	input  logic [fdes_pkg::FIELD_BITS-1:0]     slider_4,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fdes_pkg::FIELD_BITS-1:0]     smooth_0,
	output logic [fdes_pkg::FIELD_BITS-1:0]     smooth_1,
	output logic [fdes_pkg::FIELD_BITS-1:0]     smooth_2,
	output logic [fdes_pkg::FIELD_BITS-1:0]     smooth_3,
	output logic [fdes_pkg::FIELD_BITS-1:0]     smooth_4,
	input  logic                                cfg_we,
	input  logic [fdes_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fdes_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import fdes_pkg::*;

	localparam int WORD_BITS = LANES * FIELD_BITS;

	logic [CFG_DATA_BITS-1:0] deadband_q;
	logic [CFG_DATA_BITS-1:0] alpha_q;

	logic [FIELD_BITS-1:0] raw   [LANES];
	logic [FIELD_BITS-1:0] res   [LANES];
	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  out_word;
	lane_ctrl_t            ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= '0;
			alpha_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEADBAND: deadband_q <= cfg_data;
				CFG_ALPHA:    alpha_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign raw[0] = slider_0;
	assign raw[1] = slider_1;
	assign raw[2] = slider_2;
	assign raw[3] = slider_3;
	assign raw[4] = slider_4;

	assign ctrl.upd     = in_valid & ~in_stall;
	assign ctrl.restart = restart;

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			logic [SAMPLE_BITS-1:0] val;
			lane_cfg_t              cfg;

			assign cfg.band  = deadband_q[c*FIELD_BITS +: FIELD_BITS];
			assign cfg.alpha = alpha_q[c*FIELD_BITS +: FIELD_BITS];

			fdes_lane #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_lane (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.cfg   (cfg),
				.raw   (raw[c]),
				.val   (val)
			);

			assign res[c] = FIELD_BITS'(val);
		end else begin : g_off
			assign res[c] = '0;
		end
		assign word[c*FIELD_BITS +: FIELD_BITS] = res[c];
	end

	fdes_out_buf #(
		.WIDTH(WORD_BITS)
	) u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(in_valid),
		.wr_stall(in_stall),
		.wr_data (word),
		.rd_valid(out_valid),
		.rd_stall(out_stall),
		.rd_data (out_word)
	);

	assign smooth_0 = out_word[0*FIELD_BITS +: FIELD_BITS];
	assign smooth_1 = out_word[1*FIELD_BITS +: FIELD_BITS];
	assign smooth_2 = out_word[2*FIELD_BITS +: FIELD_BITS];
	assign smooth_3 = out_word[3*FIELD_BITS +: FIELD_BITS];
	assign smooth_4 = out_word[4*FIELD_BITS +: FIELD_BITS];

endmodule

FILE: src/fdes_lane.sv
// ----------------------------------------------------------------------------
// fdes_lane: one fader channel
// Holds the channel's latch flag and stored value, applies the deadband and
// the EMA step, and updates its state when a word is accepted.
// ----------------------------------------------------------------------------
module fdes_lane #(
	parameter int SAMPLE_BITS = fdes_pkg::DEF_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fdes_pkg::lane_ctrl_t            ctrl,
	input  fdes_pkg::lane_cfg_t             cfg,
	input  logic [fdes_pkg::FIELD_BITS-1:0] raw,
	output logic [SAMPLE_BITS-1:0]          val
);
	import fdes_pkg::*;

	localparam int NUM_BITS = SAMPLE_BITS + ALPHA_FRAC + 1;

	logic [SAMPLE_BITS-1:0] last_q;
	logic                   has_q;

	logic [SAMPLE_BITS-1:0] raw_m;
	logic [SAMPLE_BITS-1:0] diff;
	logic [FIELD_BITS-1:0]  diff_w;
	logic [SAMPLE_BITS-1:0] target;
	logic [FIELD_BITS-1:0]  alpha_s;
	logic [FIELD_BITS-1:0]  keep;
	logic [NUM_BITS-1:0]    num;
	logic [NUM_BITS-1:0]    rounded;
	logic                   latched;

	assign raw_m   = raw[SAMPLE_BITS-1:0];
	assign diff    = (raw_m >= last_q) ? raw_m - last_q : last_q - raw_m;
	assign diff_w  = FIELD_BITS'(diff);
	assign target  = (diff_w <= cfg.band) ? last_q : raw_m;
	assign alpha_s = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
	assign keep    = ALPHA_ONE - alpha_s;

	// two products side by side, sum never negative
	assign num     = NUM_BITS'(last_q) * NUM_BITS'(keep)
	               + NUM_BITS'(alpha_s) * NUM_BITS'(target);
	assign rounded = num + NUM_BITS'(HALF_LSB);

	// restart drops the flag for this word itself
	assign latched = has_q & ~ctrl.restart;
	assign val     = latched ? rounded[ALPHA_FRAC +: SAMPLE_BITS] : raw_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			has_q  <= 1'b0;
		end else if (ctrl.upd) begin
			last_q <= val;
			has_q  <= 1'b1;
		end
	end

endmodule

FILE: src/fdes_out_buf.sv
// ----------------------------------------------------------------------------
// fdes_out_buf: two-entry output buffer
// Output register plus skid entry; input stall comes straight from a flop.
// ----------------------------------------------------------------------------
module fdes_out_buf #(
	parameter int WIDTH = fdes_pkg::CFG_DATA_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_stall,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_stall,
	output logic [WIDTH-1:0] rd_data
);
	import fdes_pkg::*;

	logic             out_valid_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] out_data_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             take;
	logic             acc;

	assign take     = out_valid_q & ~rd_stall;
	assign acc      = wr_valid & ~skid_valid_q;
	assign wr_stall = skid_valid_q;
	assign rd_valid = out_valid_q;
	assign rd_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_data_q <= wr_data;
			end else begin
				out_data_q <= wr_data;
			end
		end
	end

endmodule
